[src/fasps_pkg.sv]
// Shared types, constants and helpers for the four-axis step pulse sequencer.
// No dependencies; every other file of the block refers to this package.
package fasps_pkg;

    localparam int AXES       = 4;   // axes with state, 1..4
    localparam int STEP_BITS  = 32;  // width of the step counters, 8..32
    localparam int FIELD_AXES = 4;   // axes carried by the request and result
    localparam int COUNT_W    = 32;
    localparam int DIV_W      = 8;
    localparam int INK_W      = 16;
    localparam int PADDR_W    = 5;
    localparam int PDATA_W    = 32;
    localparam int REG_IDX_W  = 3;

    typedef enum logic {
        OP_TICK = 1'b0,
        OP_LOAD = 1'b1
    } t_op;

    // Register indexes (byte address is 4 * index)
    localparam logic [REG_IDX_W-1:0] REG_DIV0    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_INK_LEN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_ENABLE  = 3'd5;

    typedef struct packed {
        t_op                       op;
        logic signed [COUNT_W-1:0] count_0;
        logic signed [COUNT_W-1:0] count_1;
        logic signed [COUNT_W-1:0] count_2;
        logic signed [COUNT_W-1:0] count_3;
        logic                      pause;
        logic                      ink_on;
    } t_in_item;

    typedef struct packed {
        logic [FIELD_AXES-1:0]     step_pins;
        logic [FIELD_AXES-1:0]     dir_pins;
        logic                      ink_out;
        logic                      heartbeat;
        logic                      driver_enable;
        logic                      available;
        logic signed [COUNT_W-1:0] remaining_0;
        logic signed [COUNT_W-1:0] remaining_1;
        logic signed [COUNT_W-1:0] remaining_2;
        logic signed [COUNT_W-1:0] remaining_3;
        logic [INK_W-1:0]          ink_elapsed;
    } t_out_item;

    // Per-axis state that moves through the step unit
    typedef struct packed {
        logic [STEP_BITS-1:0] steps;
        logic [DIV_W-1:0]     tick;
        logic                 level;
    } t_axis_st;

    function automatic logic is_positive(input logic [STEP_BITS-1:0] v);
        return (v != '0) && !v[STEP_BITS-1];
    endfunction

endpackage

[src/fasps_in_if.sv]
// Request channel of the step pulse sequencer: valid/ready plus one request.
// Depends on fasps_pkg for the payload type.
interface fasps_in_if;
    logic                valid;
    logic                ready;
    fasps_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/fasps_out_if.sv]
// Result channel of the step pulse sequencer: valid/ready plus one result.
// Depends on fasps_pkg for the payload type.
interface fasps_out_if;
    logic                 valid;
    logic                 ready;
    fasps_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/fasps_axis.sv]
// One axis of the sequencer: tick divider and step phase, pure logic.
// Depends on fasps_pkg for t_axis_st and is_positive.
module fasps_axis (
    input  fasps_pkg::t_axis_st              i_st,
    input  logic [fasps_pkg::DIV_W-1:0]      i_divider,
    input  logic                             i_run,
    output fasps_pkg::t_axis_st              o_st
);

    always_comb begin
        o_st = i_st;
        if (i_run) begin
            if (i_st.tick >= i_divider) begin
                o_st.tick = '0;
                if (i_st.level) begin
                    o_st.level = 1'b0;
                end else if (i_st.steps != '0) begin
                    // step toward zero
                    o_st.level = 1'b1;
                    if (fasps_pkg::is_positive(i_st.steps)) begin
                        o_st.steps = i_st.steps - 1'b1;
                    end else begin
                        o_st.steps = i_st.steps + 1'b1;
                    end
                end
            end else begin
                o_st.tick = i_st.tick + 1'b1;
            end
        end
    end

endmodule

[src/four_axis_step_pulse_sequencer.sv]
// Top level of the four-axis step pulse sequencer: channels, APB registers,
// axis state and ink timer. Depends on fasps_pkg, fasps_in_if, fasps_out_if
// and fasps_axis.
//
//  channel   direction  handshake            payload
//  i_req     in         valid / ready        op, count_0..3, pause, ink_on
//  o_rsp     out        valid / ready        pins, levels, remaining_0..3, ink_elapsed
//  apb       in         psel/penable/pready  paddr, pwdata, prdata
//
// One request per cycle while o_rsp does not stall. An accepted request sits in
// the input register while the state update and its result are formed; when
// the result stage is free, the state and the output register take them, and
// the result is offered on o_rsp until o_rsp.ready takes it.
// The input register refills in the same cycle it drains; a stalled result
// holds both stages, and i_req.ready drops only when both are full and
// o_rsp.ready is low.
// i_rst_n is synchronous, active low: state goes to zero, heartbeat to one,
// driver enable level to one. There is no clearing pass.
module four_axis_step_pulse_sequencer (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    fasps_in_if.sink                           i_req,
    fasps_out_if.source                        o_rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fasps_pkg::PADDR_W-1:0]      paddr,
    input  logic [fasps_pkg::PDATA_W-1:0]      pwdata,
    output logic [fasps_pkg::PDATA_W-1:0]      prdata,
    output logic                               pready
);

    localparam int AXES       = fasps_pkg::AXES;
    localparam int STEP_BITS  = fasps_pkg::STEP_BITS;
    localparam int FIELD_AXES = fasps_pkg::FIELD_AXES;
    localparam int COUNT_W    = fasps_pkg::COUNT_W;
    localparam int DIV_W      = fasps_pkg::DIV_W;
    localparam int INK_W      = fasps_pkg::INK_W;
    localparam int PDATA_W    = fasps_pkg::PDATA_W;
    localparam int REG_IDX_W  = fasps_pkg::REG_IDX_W;

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    logic [DIV_W-1:0]     r_div     [AXES];
    logic [INK_W-1:0]     r_ink_len;
    logic                 r_enable;

    logic [STEP_BITS-1:0] r_active  [AXES];
    logic [STEP_BITS-1:0] r_pend    [AXES];
    logic [DIV_W-1:0]     r_tick    [AXES];
    logic [AXES-1:0]      r_step;
    logic [AXES-1:0]      r_dir;
    logic [INK_W-1:0]     r_ink_timer;
    logic                 r_ink;
    logic                 r_hb;

    logic [DIV_W-1:0]     n_div     [AXES];
    logic [INK_W-1:0]     n_ink_len;
    logic                 n_enable;
    logic [STEP_BITS-1:0] n_active  [AXES];
    logic [STEP_BITS-1:0] n_pend    [AXES];
    logic [DIV_W-1:0]     n_tick    [AXES];
    logic [AXES-1:0]      n_step;
    logic [AXES-1:0]      n_dir;
    logic [INK_W-1:0]     n_ink_timer;
    logic                 n_ink;
    logic                 n_hb;

    fasps_pkg::t_in_item  r_in;
    logic                 r_in_vld;
    fasps_pkg::t_out_item r_out;
    logic                 r_out_vld;
    fasps_pkg::t_out_item n_out;

    // ---------------------------------------------------------------
    // Handshake: two stages, each advances when the next one frees up
    // ---------------------------------------------------------------
    logic out_free;
    logic advance;
    logic in_take;

    assign out_free    = !r_out_vld || o_rsp.ready;
    assign advance     = r_in_vld && out_free;
    assign i_req.ready = !r_in_vld || out_free;
    assign in_take     = i_req.valid && i_req.ready;
    assign o_rsp.valid = r_out_vld;
    assign o_rsp.data  = r_out;

    // ---------------------------------------------------------------
    // APB register port
    // ---------------------------------------------------------------
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] cfg_idx;
    logic                 cfg_clear;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready;
    assign cfg_idx   = paddr[REG_IDX_W+1:2];
    // divider and ink length writes zero the tick counters and set the ink timer to the ink length
    assign cfg_clear = (cfg_idx < fasps_pkg::REG_INK_LEN) || (cfg_idx == fasps_pkg::REG_INK_LEN);

    always_comb begin
        prdata = '0;
        for (int i = 0; i < AXES; i++) begin
            if (cfg_idx == REG_IDX_W'(i) + fasps_pkg::REG_DIV0) begin
                prdata = PDATA_W'(r_div[i]);
            end
        end
        if (cfg_idx == fasps_pkg::REG_INK_LEN) begin
            prdata = PDATA_W'(r_ink_len);
        end
        if (cfg_idx == fasps_pkg::REG_ENABLE) begin
            prdata = PDATA_W'(r_enable);
        end
    end

    // ---------------------------------------------------------------
    // Axis step units, one per axis
    // ---------------------------------------------------------------
    logic                run;
    fasps_pkg::t_axis_st ax_cur [AXES];
    fasps_pkg::t_axis_st ax_nxt [AXES];

    assign run = advance && (r_in.op == fasps_pkg::OP_TICK) && !r_in.pause;

    for (genvar g = 0; g < AXES; g++) begin : g_axis
        assign ax_cur[g] = '{steps: r_active[g], tick: r_tick[g], level: r_step[g]};

        fasps_axis u_axis (
            .i_st      (ax_cur[g]),
            .i_divider (r_div[g]),
            .i_run     (run),
            .o_st      (ax_nxt[g])
        );
    end

    // ---------------------------------------------------------------
    // Whole-block zero checks
    // ---------------------------------------------------------------
    logic act_zero;     // current active counts all zero
    logic pend_zero;    // current pending buffer all zero
    logic nxt_zero;     // active counts after this tick's step phases

    always_comb begin
        act_zero  = 1'b1;
        pend_zero = 1'b1;
        nxt_zero  = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            if (r_active[i] != '0)     act_zero  = 1'b0;
            if (r_pend[i] != '0)       pend_zero = 1'b0;
            if (ax_nxt[i].steps != '0) nxt_zero  = 1'b0;
        end
    end

    // request counts as an array, truncated to the step counter width on load
    logic [COUNT_W-1:0] in_counts [FIELD_AXES];

    assign in_counts[0] = r_in.count_0;
    assign in_counts[1] = r_in.count_1;
    assign in_counts[2] = r_in.count_2;
    assign in_counts[3] = r_in.count_3;

    // ---------------------------------------------------------------
    // Next state
    // ---------------------------------------------------------------
    logic             move_ended;
    logic [INK_W-1:0] ink_base;

    assign move_ended = !act_zero && nxt_zero;
    assign ink_base   = move_ended ? '0 : r_ink_timer;

    always_comb begin
        n_div       = r_div;
        n_ink_len   = r_ink_len;
        n_enable    = r_enable;
        n_active    = r_active;
        n_pend      = r_pend;
        n_tick      = r_tick;
        n_step      = r_step;
        n_dir       = r_dir;
        n_ink_timer = r_ink_timer;
        n_ink       = r_ink;
        n_hb        = r_hb;

        if (cfg_wr) begin
            for (int i = 0; i < AXES; i++) begin
                if (cfg_idx == REG_IDX_W'(i) + fasps_pkg::REG_DIV0) begin
                    n_div[i] = pwdata[DIV_W-1:0];
                end
            end
            if (cfg_idx == fasps_pkg::REG_INK_LEN) begin
                n_ink_len = pwdata[INK_W-1:0];
            end
            if (cfg_idx == fasps_pkg::REG_ENABLE) begin
                n_enable = pwdata[0];
            end
            if (cfg_clear) begin
                for (int i = 0; i < AXES; i++) begin
                    n_tick[i] = '0;
                end
                n_ink_timer = n_ink_len;
            end
        end else if (advance) begin
            priority if (r_in.op == fasps_pkg::OP_LOAD) begin
                // load overwrites the buffer whatever pause says
                for (int i = 0; i < AXES; i++) begin
                    if (i < FIELD_AXES) begin
                        n_pend[i] = in_counts[i][STEP_BITS-1:0];
                    end else begin
                        n_pend[i] = '0;
                    end
                end
            end else if (r_in.pause) begin
                n_hb = 1'b1;
            end else begin
                n_hb = !r_hb;
                for (int i = 0; i < AXES; i++) begin
                    n_active[i] = ax_nxt[i].steps;
                    n_tick[i]   = ax_nxt[i].tick;
                    n_step[i]   = ax_nxt[i].level;
                end

                // ink: timed pulse after each move, or level while idle
                if (r_ink_len != '0) begin
                    if (ink_base < r_ink_len) begin
                        n_ink       = 1'b1;
                        n_ink_timer = ink_base + 1'b1;
                    end else begin
                        n_ink       = 1'b0;
                        n_ink_timer = ink_base;
                    end
                end else if (nxt_zero) begin
                    n_ink = r_in.ink_on;
                end

                // all axes idle: start the next move from the buffer
                if (nxt_zero && !pend_zero) begin
                    for (int i = 0; i < AXES; i++) begin
                        n_active[i] = r_pend[i];
                        n_pend[i]   = '0;
                        n_dir[i]    = fasps_pkg::is_positive(r_pend[i]);
                        n_tick[i]   = '0;
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result from the state after this request
    // ---------------------------------------------------------------
    logic               n_pend_zero;
    logic [COUNT_W-1:0] rem [FIELD_AXES];

    always_comb begin
        n_pend_zero = 1'b1;
        for (int i = 0; i < AXES; i++) begin
            if (n_pend[i] != '0) n_pend_zero = 1'b0;
        end

        n_out.step_pins = '0;
        n_out.dir_pins  = '0;
        for (int i = 0; i < FIELD_AXES; i++) begin
            if (i < AXES) begin
                n_out.step_pins[i] = n_step[i];
                n_out.dir_pins[i]  = n_dir[i];
                rem[i]             = COUNT_W'($signed(n_active[i]));
            end else begin
                rem[i]             = '0;
            end
        end
        n_out.ink_out       = n_ink;
        n_out.heartbeat     = n_hb;
        n_out.driver_enable = n_enable;
        n_out.available     = n_pend_zero || r_in.pause;
        n_out.remaining_0   = rem[0];
        n_out.remaining_1   = rem[1];
        n_out.remaining_2   = rem[2];
        n_out.remaining_3   = rem[3];
        n_out.ink_elapsed   = n_ink_timer;
    end

    // ---------------------------------------------------------------
    // Clocked state
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < AXES; i++) begin
                r_div[i]    <= '0;
                r_active[i] <= '0;
                r_pend[i]   <= '0;
                r_tick[i]   <= '0;
            end
            r_ink_len   <= '0;
            r_enable    <= 1'b1;
            r_step      <= '0;
            r_dir       <= '0;
            r_ink_timer <= '0;
            r_ink       <= 1'b0;
            r_hb        <= 1'b1;
            r_in_vld    <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_div       <= n_div;
            r_ink_len   <= n_ink_len;
            r_enable    <= n_enable;
            r_active    <= n_active;
            r_pend      <= n_pend;
            r_tick      <= n_tick;
            r_step      <= n_step;
            r_dir       <= n_dir;
            r_ink_timer <= n_ink_timer;
            r_ink       <= n_ink;
            r_hb        <= n_hb;
            r_in_vld    <= in_take || (r_in_vld && !advance);
            r_out_vld   <= advance || (r_out_vld && !o_rsp.ready);
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in <= i_req.data;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // an unpaused tick never leaves idle axes with a full buffer behind
    a_buffer_drains : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        run |=> !(act_zero && !pend_zero))
        else $error("pending buffer left behind idle axes after a tick");

    // a paused tick reports the heartbeat high
    a_pause_hb : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && (r_in.op == fasps_pkg::OP_TICK) && r_in.pause |=> r_out.heartbeat)
        else $error("heartbeat not high on a paused tick");

    // the ink timer never runs past the pulse length
    a_ink_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ink_timer <= r_ink_len)
        else $error("ink timer beyond pulse length");

endmodule
